### rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int HEAP_BLOCKS = 1024;
    localparam int ADDR_W      = $clog2(HEAP_BLOCKS);
    localparam int LINK_W      = 11;
    localparam int SIZE_W      = 32;
    localparam int WANT_W      = 11;
    localparam int STEP_W      = $clog2(HEAP_BLOCKS + 1);
    localparam int STATUS_W    = 2;
    localparam int GRANT_W     = 10;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;

    typedef struct packed {
        logic              rd;
        logic              wr_size;
        logic              wr_next;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size_wdata;
        logic [LINK_W-1:0] next_wdata;
    } mem_req_t;

    function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
    endfunction

    function automatic logic ends_at(input logic [LINK_W-1:0] start,
                                     input logic [SIZE_W-1:0] len,
                                     input logic [LINK_W-1:0] other);
        logic [SIZE_W:0] e;
        e = {{(SIZE_W+1-LINK_W){1'b0}}, start} + {1'b0, len};
        return e == {{(SIZE_W+1-LINK_W){1'b0}}, other};
    endfunction

endpackage

`default_nettype wire

### rtl/ffba_mem.sv
// ----------------------------------------------------------------------------
// ffba_mem
// Header memory: fragment size and next link per block, one access a cycle,
// registered read data; entry 0 reads its reset header until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ffba_pkg::mem_req_t        req,
    output logic [ffba_pkg::SIZE_W-1:0]    rd_size,
    output logic [ffba_pkg::LINK_W-1:0]    rd_next
);
    import ffba_pkg::*;

    logic [SIZE_W-1:0] size_mem [HEAP_BLOCKS];
    logic [LINK_W-1:0] next_mem [HEAP_BLOCKS];
    logic [SIZE_W-1:0] size_q_reg;
    logic [LINK_W-1:0] next_q_reg;
    logic              sz0_ok_reg;
    logic              nx0_ok_reg;
    logic              sz_ovr_reg;
    logic              nx_ovr_reg;
    logic              at_zero;

    assign at_zero = (req.addr == '0);

    always_ff @(posedge clk)
    begin
        if (req.wr_size)
        begin
            size_mem[req.addr] <= req.size_wdata;
        end
        if (req.wr_next)
        begin
            next_mem[req.addr] <= req.next_wdata;
        end
        if (req.rd)
        begin
            size_q_reg <= size_mem[req.addr];
            next_q_reg <= next_mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sz0_ok_reg <= 1'b0;
            nx0_ok_reg <= 1'b0;
            sz_ovr_reg <= 1'b0;
            nx_ovr_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_size && at_zero)
            begin
                sz0_ok_reg <= 1'b1;
            end
            if (req.wr_next && at_zero)
            begin
                nx0_ok_reg <= 1'b1;
            end
            if (req.rd)
            begin
                sz_ovr_reg <= at_zero && !sz0_ok_reg;
                nx_ovr_reg <= at_zero && !nx0_ok_reg;
            end
        end
    end

    assign rd_size = sz_ovr_reg ? SIZE_W'(HEAP_BLOCKS) : size_q_reg;
    assign rd_next = nx_ovr_reg ? LINK_W'(HEAP_BLOCKS) : next_q_reg;

endmodule

`default_nettype wire

### rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low: req_type 0
// allocates alloc_blocks blocks, req_type 1 frees the fragment at free_block.
// One result word follows per request, shown for one cycle with done high:
// status and alloc_block (start index of the grant, 0 otherwise). The
// receiver cannot stall; done is a single-cycle strobe.
// Rejected requests answer straight from idle. An allocation checks the
// fragments one per cycle and answers if nothing fits; on a fit it writes the
// grant size and tail header on a split (the header only if the tail lies in
// the heap), then the link, one per cycle. A free tests and steps past each
// fragment before the freed index, reads the freed header, merges it into the
// previous fragment or links it in, then reads the next one to merge with it.
// Each step makes at most one access to the single-port header memory.
// Allocation walks check at most HEAP_BLOCKS + 1 fragments, free walks at most
// HEAP_BLOCKS. One request is in flight at a time; busy is low when done is high.
// Reset: the whole heap is one free fragment at block 0; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           req_type,
    input  wire logic [ffba_pkg::WANT_W-1:0]    alloc_blocks,
    input  wire logic [ffba_pkg::LINK_W-1:0]    free_block,
    input  wire logic                           free_null,
    output logic                                done,
    output logic [ffba_pkg::STATUS_W-1:0]       status,
    output logic [ffba_pkg::GRANT_W-1:0]        alloc_block
);
    import ffba_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_CHK  = 4'd1;
    localparam logic [3:0] S_A_SP1  = 4'd2;
    localparam logic [3:0] S_A_SP2  = 4'd3;
    localparam logic [3:0] S_A_LINK = 4'd4;
    localparam logic [3:0] S_F_TEST = 4'd5;
    localparam logic [3:0] S_F_STEP = 4'd6;
    localparam logic [3:0] S_F_BLK  = 4'd7;
    localparam logic [3:0] S_F_P1   = 4'd8;
    localparam logic [3:0] S_F_P1L  = 4'd9;
    localparam logic [3:0] S_F_CUR  = 4'd10;
    localparam logic [3:0] S_F_P2   = 4'd11;

    localparam logic [LINK_W-1:0] HEAP_L = LINK_W'(HEAP_BLOCKS);
    localparam logic [STEP_W-1:0] HEAP_S = STEP_W'(HEAP_BLOCKS);

    logic [3:0]         state_reg, state_next;
    logic [LINK_W-1:0]  head_reg, head_next;
    logic [LINK_W-1:0]  cur_reg, cur_next;
    logic [LINK_W-1:0]  prev_reg, prev_next;
    logic               has_prev_reg, has_prev_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [WANT_W-1:0]  want_reg, want_next;
    logic [LINK_W-1:0]  blk_reg, blk_next;
    logic [SIZE_W-1:0]  csize_reg, csize_next;
    logic [LINK_W-1:0]  cnext_reg, cnext_next;
    logic [LINK_W-1:0]  link_reg, link_next;
    logic [LINK_W-1:0]  node_reg, node_next;
    logic [SIZE_W-1:0]  nsize_reg, nsize_next;
    logic               done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [GRANT_W-1:0] grant_reg, grant_next;

    mem_req_t           mreq;
    logic [SIZE_W-1:0]  rd_size;
    logic [LINK_W-1:0]  rd_next;
    logic [LINK_W:0]    tail;
    logic [SIZE_W-1:0]  sum;

    ffba_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .rd_size (rd_size),
        .rd_next (rd_next)
    );

    assign tail = {1'b0, cur_reg} + {1'b0, want_reg};

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        has_prev_next = has_prev_reg;
        steps_next    = steps_reg;
        want_next     = want_reg;
        blk_next      = blk_reg;
        csize_next    = csize_reg;
        cnext_next    = cnext_reg;
        link_next     = link_reg;
        node_next     = node_reg;
        nsize_next    = nsize_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        grant_next    = grant_reg;
        mreq          = '0;
        sum           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    want_next     = alloc_blocks;
                    blk_next      = free_block;
                    cur_next      = head_reg;
                    steps_next    = '0;
                    has_prev_next = 1'b0;
                    grant_next    = '0;
                    if (req_type == REQ_ALLOC)
                    begin
                        if (alloc_blocks == '0 || head_reg >= HEAP_L)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NO_FIT;
                        end
                        else
                        begin
                            mreq.rd    = 1'b1;
                            mreq.addr  = head_reg[ADDR_W-1:0];
                            state_next = S_A_CHK;
                        end
                    end
                    else if (free_null)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NULL;
                    end
                    else if (free_block >= HEAP_L)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        state_next = S_F_TEST;
                    end
                end
            end
            S_A_CHK:
            begin
                if (rd_size < {{(SIZE_W-WANT_W){1'b0}}, want_reg})
                begin
                    if (steps_reg == HEAP_S || rd_next >= HEAP_L)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NO_FIT;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        steps_next    = steps_reg + 1'b1;
                        prev_next     = cur_reg;
                        has_prev_next = 1'b1;
                        cur_next      = rd_next;
                        mreq.rd       = 1'b1;
                        mreq.addr     = rd_next[ADDR_W-1:0];
                    end
                end
                else
                begin
                    csize_next = rd_size;
                    cnext_next = rd_next;
                    if (rd_size == {{(SIZE_W-WANT_W){1'b0}}, want_reg})
                    begin
                        link_next  = rd_next;
                        state_next = S_A_LINK;
                    end
                    else
                    begin
                        state_next = S_A_SP1;
                    end
                end
            end
            S_A_SP1:
            begin
                mreq.wr_size    = 1'b1;
                mreq.addr       = cur_reg[ADDR_W-1:0];
                mreq.size_wdata = {{(SIZE_W-WANT_W){1'b0}}, want_reg};
                if (tail < {1'b0, HEAP_L})
                begin
                    state_next = S_A_SP2;
                end
                else
                begin
                    link_next  = cnext_reg;
                    state_next = S_A_LINK;
                end
            end
            S_A_SP2:
            begin
                mreq.wr_size    = 1'b1;
                mreq.wr_next    = 1'b1;
                mreq.addr       = tail[ADDR_W-1:0];
                mreq.size_wdata = csize_reg - {{(SIZE_W-WANT_W){1'b0}}, want_reg};
                mreq.next_wdata = cnext_reg;
                link_next       = tail[LINK_W-1:0];
                state_next      = S_A_LINK;
            end
            S_A_LINK:
            begin
                if (has_prev_reg)
                begin
                    mreq.wr_next    = 1'b1;
                    mreq.addr       = prev_reg[ADDR_W-1:0];
                    mreq.next_wdata = link_reg;
                end
                else
                begin
                    head_next = link_reg;
                end
                done_next   = 1'b1;
                status_next = ST_OK;
                grant_next  = cur_reg[GRANT_W-1:0];
                state_next  = S_IDLE;
            end
            S_F_TEST:
            begin
                if (cur_reg < HEAP_L && cur_reg < blk_reg && steps_reg != HEAP_S)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = cur_reg[ADDR_W-1:0];
                    state_next = S_F_STEP;
                end
                else
                begin
                    state_next = S_F_BLK;
                end
            end
            S_F_STEP:
            begin
                steps_next    = steps_reg + 1'b1;
                prev_next     = cur_reg;
                has_prev_next = 1'b1;
                csize_next    = rd_size;
                cur_next      = rd_next;
                state_next    = S_F_TEST;
            end
            S_F_BLK:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = blk_reg[ADDR_W-1:0];
                state_next = S_F_P1;
            end
            S_F_P1:
            begin
                if (has_prev_reg && ends_at(prev_reg, csize_reg, blk_reg))
                begin
                    sum             = sat_add(csize_reg, rd_size);
                    mreq.wr_size    = 1'b1;
                    mreq.addr       = prev_reg[ADDR_W-1:0];
                    mreq.size_wdata = sum;
                    node_next       = prev_reg;
                    nsize_next      = sum;
                    state_next      = S_F_CUR;
                end
                else
                begin
                    mreq.wr_next    = 1'b1;
                    mreq.addr       = blk_reg[ADDR_W-1:0];
                    mreq.next_wdata = cur_reg;
                    node_next       = blk_reg;
                    nsize_next      = rd_size;
                    state_next      = S_F_P1L;
                end
            end
            S_F_P1L:
            begin
                if (has_prev_reg)
                begin
                    mreq.wr_next    = 1'b1;
                    mreq.addr       = prev_reg[ADDR_W-1:0];
                    mreq.next_wdata = blk_reg;
                end
                else
                begin
                    head_next = blk_reg;
                end
                state_next = S_F_CUR;
            end
            S_F_CUR:
            begin
                if (cur_reg < HEAP_L)
                begin
                    mreq.rd    = 1'b1;
                    mreq.addr  = cur_reg[ADDR_W-1:0];
                    state_next = S_F_P2;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_F_P2:
            begin
                if (ends_at(node_reg, nsize_reg, cur_reg))
                begin
                    mreq.wr_size    = 1'b1;
                    mreq.wr_next    = 1'b1;
                    mreq.addr       = node_reg[ADDR_W-1:0];
                    mreq.size_wdata = sat_add(nsize_reg, rd_size);
                    mreq.next_wdata = rd_next;
                end
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        steps_reg    <= steps_next;
        want_reg     <= want_next;
        blk_reg      <= blk_next;
        csize_reg    <= csize_next;
        cnext_reg    <= cnext_next;
        link_reg     <= link_next;
        node_reg     <= node_next;
        nsize_reg    <= nsize_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign alloc_block = grant_reg;

endmodule

`default_nettype wire
